// ----- design/gicf_pkg.sv -----
// ---------------------------------------------------------------------------
// gicf_pkg
// Shared types, constants and the micro-program of the GNSS / inertial
// position fusion block.
// ---------------------------------------------------------------------------
package gicf_pkg;

  // Field widths
  localparam int POS_W      = 40;
  localparam int CNT_W      = 16;
  localparam int YAW_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int LIM_W      = CFG_W + 8;          // distance limit in 1/256 mm
  localparam int WGT_W      = CFG_W + 1;          // 65536 - alpha
  localparam int ERR_W      = POS_W + 1;          // exact difference of positions
  localparam int MUL_A_W    = POS_W + 1;
  localparam int MUL_B_W    = LIM_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int STEP_W     = 5;
  localparam int STATUS_W   = 3;

  // Stream word widths
  localparam int IN_FIELDS_W  = 4 * POS_W + YAW_W + 2 + CNT_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * POS_W + YAW_W + 2 + STATUS_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Register reset values
  localparam logic [CFG_W-1:0] ALPHA_RESET  = 16'd64225;
  localparam logic [CFG_W-1:0] SINE_RESET   = 16'd0;
  localparam logic [CFG_W-1:0] COSINE_RESET = 16'd32767;
  localparam logic [CFG_W-1:0] DIST_RESET   = 16'd5000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COSINE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST   = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_NOT_READY = 3'd0,
    ST_INERT     = 3'd1,
    ST_BLEND     = 3'd2,
    ST_REJECT    = 3'd3,
    ST_FRAME     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    A_EAST, A_NORTH, A_ERR_X, A_ERR_Y, A_LIM
  } a_sel_e;

  typedef enum logic [2:0] {
    B_SINE, B_COSINE, B_ERR_X, B_ERR_Y, B_LIM, B_WEIGHT
  } b_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_NEG
  } acc_op_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_PREDICT, OP_LATCH_FIX, OP_GX, OP_GY, OP_ERR, OP_UPD_X, OP_UPD_Y,
    OP_FRAME
  } dp_op_e;

  typedef enum logic [2:0] {
    CND_NEVER, CND_ALWAYS, CND_KIND, CND_NOT_READY, CND_NO_FIX, CND_FAR, CND_ACC_POS
  } cond_e;

  // One control word of the micro-program
  typedef struct packed {
    a_sel_e              mul_a;
    b_sel_e              mul_b;
    acc_op_e             acc_op;
    dp_op_e              op;
    logic                stat_we;
    status_e             stat;
    cond_e               cond;
    logic [STEP_W-1:0]   target;
    logic                fin;
  } ctrl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic kind;
    logic ready;
    logic fix_new;
    logic far;
    logic acc_pos;
  } flags_t;

  typedef struct packed {
    logic                     kind;
    logic signed [POS_W-1:0]  inertial_x;
    logic signed [POS_W-1:0]  inertial_y;
    logic signed [YAW_W-1:0]  yaw_in;
    logic signed [POS_W-1:0]  gnss_east;
    logic signed [POS_W-1:0]  gnss_north;
    logic                     gnss_valid;
    logic                     gnss_origin_set;
    logic [CNT_W-1:0]         gnss_count;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  fused_x;
    logic signed [POS_W-1:0]  fused_y;
    logic signed [YAW_W-1:0]  yaw_out;
    logic                     frame_ready;
    logic                     gnss_seen;
    status_e                  status;
  } res_t;

  // Program labels
  localparam logic [STEP_W-1:0] L_REJ   = 5'd20;
  localparam logic [STEP_W-1:0] L_FRAME = 5'd21;
  localparam logic [STEP_W-1:0] L_FIN   = 5'd22;

  function automatic ctrl_t mk(a_sel_e a, b_sel_e b, acc_op_e acc, dp_op_e op,
                               logic stat_we, status_e stat, cond_e cond,
                               logic [STEP_W-1:0] target, logic fin);
    ctrl_t w;
    w.mul_a   = a;
    w.mul_b   = b;
    w.acc_op  = acc;
    w.op      = op;
    w.stat_we = stat_we;
    w.stat    = stat;
    w.cond    = cond;
    w.target  = target;
    w.fin     = fin;
    return w;
  endfunction

  // Micro-program. The multiplier result of a step is used by the next one.
  function automatic ctrl_t ucode_rom(logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      // dispatch on the item
      5'd0: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_NONE, 1'b0, ST_NOT_READY,
                   CND_KIND, L_FRAME, 1'b0);
      5'd1: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_NONE, 1'b0, ST_NOT_READY,
                   CND_NOT_READY, L_FIN, 1'b0);
      5'd2: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_PREDICT, 1'b1, ST_INERT,
                   CND_NO_FIX, L_FIN, 1'b0);
      // rotate the fix: gx = -(E*S + N*C), gy = E*C - N*S
      5'd3: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_LATCH_FIX, 1'b0, ST_NOT_READY,
                   CND_NEVER, L_FIN, 1'b0);
      5'd4: w = mk(A_NORTH, B_COSINE, ACC_NEG, OP_NONE, 1'b0, ST_NOT_READY,
                   CND_NEVER, L_FIN, 1'b0);
      5'd5: w = mk(A_EAST, B_COSINE, ACC_SUB, OP_NONE, 1'b0, ST_NOT_READY,
                   CND_NEVER, L_FIN, 1'b0);
      5'd6: w = mk(A_NORTH, B_SINE, ACC_LOAD, OP_GX, 1'b0, ST_NOT_READY,
                   CND_NEVER, L_FIN, 1'b0);
      5'd7: w = mk(A_EAST, B_SINE, ACC_SUB, OP_NONE, 1'b0, ST_NOT_READY,
                   CND_NEVER, L_FIN, 1'b0);
      5'd8: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_GY, 1'b0, ST_NOT_READY,
                   CND_NEVER, L_FIN, 1'b0);
      // error against the prediction, coarse distance check
      5'd9: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_ERR, 1'b0, ST_NOT_READY,
                   CND_NEVER, L_FIN, 1'b0);
      5'd10: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_NONE, 1'b0, ST_NOT_READY,
                    CND_FAR, L_REJ, 1'b0);
      // squared distance against squared limit
      5'd11: w = mk(A_ERR_X, B_ERR_X, ACC_HOLD, OP_NONE, 1'b0, ST_NOT_READY,
                    CND_NEVER, L_FIN, 1'b0);
      5'd12: w = mk(A_ERR_Y, B_ERR_Y, ACC_LOAD, OP_NONE, 1'b0, ST_NOT_READY,
                    CND_NEVER, L_FIN, 1'b0);
      5'd13: w = mk(A_LIM, B_LIM, ACC_ADD, OP_NONE, 1'b0, ST_NOT_READY,
                    CND_NEVER, L_FIN, 1'b0);
      5'd14: w = mk(A_EAST, B_SINE, ACC_SUB, OP_NONE, 1'b0, ST_NOT_READY,
                    CND_NEVER, L_FIN, 1'b0);
      5'd15: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_NONE, 1'b0, ST_NOT_READY,
                    CND_ACC_POS, L_REJ, 1'b0);
      // blend with the GNSS weight
      5'd16: w = mk(A_ERR_X, B_WEIGHT, ACC_HOLD, OP_NONE, 1'b0, ST_NOT_READY,
                    CND_NEVER, L_FIN, 1'b0);
      5'd17: w = mk(A_ERR_Y, B_WEIGHT, ACC_LOAD, OP_NONE, 1'b0, ST_NOT_READY,
                    CND_NEVER, L_FIN, 1'b0);
      5'd18: w = mk(A_EAST, B_SINE, ACC_LOAD, OP_UPD_X, 1'b0, ST_NOT_READY,
                    CND_NEVER, L_FIN, 1'b0);
      5'd19: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_UPD_Y, 1'b1, ST_BLEND,
                    CND_ALWAYS, L_FIN, 1'b0);
      5'd20: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_NONE, 1'b1, ST_REJECT,
                    CND_ALWAYS, L_FIN, 1'b0);
      5'd21: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_FRAME, 1'b1, ST_FRAME,
                    CND_ALWAYS, L_FIN, 1'b0);
      5'd22: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_NONE, 1'b0, ST_NOT_READY,
                    CND_NEVER, L_FIN, 1'b1);
      default: w = mk(A_EAST, B_SINE, ACC_HOLD, OP_NONE, 1'b0, ST_NOT_READY,
                      CND_ALWAYS, L_FIN, 1'b0);
    endcase
    return w;
  endfunction

endpackage

// ----- design/gicf_seq.sv -----
// ---------------------------------------------------------------------------
// gicf_seq
// Micro-program sequencer: step counter, control word fetch and
// conditional jumps.
// ---------------------------------------------------------------------------
module gicf_seq import gicf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,     // word accepted, run the program from step 0
  input  logic   out_free_i,  // output register can take a result
  input  flags_t flags_i,
  output ctrl_t  ctrl_o,
  output logic   busy_o,
  output logic   done_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              run_q, run_d;
  ctrl_t             cw;
  logic              cond_hit;

  assign cw = ucode_rom(step_q);

  // Evaluate the jump condition of the current word
  always_comb begin
    case (cw.cond)
      CND_NEVER:     cond_hit = 1'b0;
      CND_ALWAYS:    cond_hit = 1'b1;
      CND_KIND:      cond_hit = flags_i.kind;
      CND_NOT_READY: cond_hit = ~flags_i.ready;
      CND_NO_FIX:    cond_hit = ~flags_i.fix_new;
      CND_FAR:       cond_hit = flags_i.far;
      CND_ACC_POS:   cond_hit = flags_i.acc_pos;
      default:       cond_hit = 1'b0;
    endcase
  end

  // Advance, jump, or hold on the final step until the result is taken
  always_comb begin
    step_d = step_q;
    run_d  = run_q;
    if (start_i) begin
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (cw.fin) begin
        if (out_free_i) begin
          run_d = 1'b0;
        end
      end else if (cond_hit) begin
        step_d = cw.target;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      run_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      run_q  <= run_d;
    end
  end

  assign ctrl_o = run_q ? cw : '0;
  assign busy_o = run_q;
  assign done_o = run_q & cw.fin & out_free_i;

endmodule

// ----- design/gicf_dp.sv -----
// ---------------------------------------------------------------------------
// gicf_dp
// Fusion datapath: configuration registers, fused state, one shared
// multiplier and an accumulator, all steered by the control word.
// ---------------------------------------------------------------------------
module gicf_dp import gicf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ctrl_t                 ctrl_i,
  input  item_t                 item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output flags_t                flags_o,
  output res_t                  res_o
);

  localparam logic signed [PROD_W-1:0] RND15 = PROD_W'(16384);
  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(32768);
  localparam int SAT_LO = POS_W + 14;

  // Configuration
  logic [CFG_W-1:0]        alpha_q, sine_q, cosine_q, dist_q;
  // Fused state
  logic signed [POS_W-1:0] pos_x_q, pos_y_q, prev_ix_q, prev_iy_q;
  logic signed [YAW_W-1:0] yaw_q;
  logic [CNT_W-1:0]        prev_cnt_q;
  logic                    ready_q, seen_q;
  status_e                 status_q;
  // Working registers
  logic signed [PROD_W-1:0] prod_q, acc_q;
  logic signed [ERR_W-1:0]  ex_q, ey_q;

  logic [LIM_W-1:0]          lim;
  logic [WGT_W-1:0]          weight;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  rnd_t, bl_t;
  logic                      in_range;
  logic signed [POS_W-1:0]   g_sat, delta;
  logic [ERR_W-1:0]          mag_x, mag_y;

  assign lim    = {dist_q, 8'h00};
  assign weight = WGT_W'({1'b1, {CFG_W{1'b0}}} - {1'b0, alpha_q});

  // Select multiplier operands
  always_comb begin
    case (ctrl_i.mul_a)
      A_EAST:  mul_a = {item_i.gnss_east[POS_W-1], item_i.gnss_east};
      A_NORTH: mul_a = {item_i.gnss_north[POS_W-1], item_i.gnss_north};
      A_ERR_X: mul_a = ex_q;
      A_ERR_Y: mul_a = ey_q;
      A_LIM:   mul_a = {{(MUL_A_W-LIM_W){1'b0}}, lim};
      default: mul_a = '0;
    endcase
    case (ctrl_i.mul_b)
      B_SINE:   mul_b = {{(MUL_B_W-CFG_W){sine_q[CFG_W-1]}}, sine_q};
      B_COSINE: mul_b = {{(MUL_B_W-CFG_W){cosine_q[CFG_W-1]}}, cosine_q};
      B_ERR_X:  mul_b = ex_q[MUL_B_W-1:0];
      B_ERR_Y:  mul_b = ey_q[MUL_B_W-1:0];
      B_LIM:    mul_b = {1'b0, lim};
      B_WEIGHT: mul_b = {{(MUL_B_W-WGT_W){1'b0}}, weight};
      default:  mul_b = '0;
    endcase
  end

  // Round the rotation sum by 15 bits and saturate to the position range
  assign rnd_t    = acc_q + RND15;
  assign in_range = (&rnd_t[PROD_W-1:SAT_LO]) | ~(|rnd_t[PROD_W-1:SAT_LO]);
  assign g_sat    = in_range ? rnd_t[SAT_LO:15]
                  : (rnd_t[PROD_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                     : {1'b0, {(POS_W-1){1'b1}}});

  // Blend step: round the weighted error by 16 bits
  assign bl_t  = acc_q + RND16;
  assign delta = bl_t[POS_W+15:16];

  // Error magnitudes for the coarse distance check
  assign mag_x = ex_q[ERR_W-1] ? ERR_W'(-ex_q) : ex_q;
  assign mag_y = ey_q[ERR_W-1] ? ERR_W'(-ey_q) : ey_q;

  // Multiply, accumulate, hold errors
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_q <= prod_q;
      ACC_ADD:  acc_q <= acc_q + prod_q;
      ACC_SUB:  acc_q <= acc_q - prod_q;
      ACC_NEG:  acc_q <= -prod_q;
      default:  acc_q <= acc_q;
    endcase
    case (ctrl_i.op)
      OP_GX:  ex_q <= {g_sat[POS_W-1], g_sat};
      OP_GY:  ey_q <= {g_sat[POS_W-1], g_sat};
      OP_ERR: begin
        ex_q <= ex_q - {pos_x_q[POS_W-1], pos_x_q};
        ey_q <= ey_q - {pos_y_q[POS_W-1], pos_y_q};
      end
      default: begin
        ex_q <= ex_q;
        ey_q <= ey_q;
      end
    endcase
  end

  // Configuration and fused state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= ALPHA_RESET;
      sine_q     <= SINE_RESET;
      cosine_q   <= COSINE_RESET;
      dist_q     <= DIST_RESET;
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      prev_ix_q  <= '0;
      prev_iy_q  <= '0;
      yaw_q      <= '0;
      prev_cnt_q <= '0;
      ready_q    <= 1'b0;
      seen_q     <= 1'b0;
      status_q   <= ST_NOT_READY;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ALPHA:  alpha_q  <= cfg_wdata_i;
          CFG_SINE:   sine_q   <= cfg_wdata_i;
          CFG_COSINE: cosine_q <= cfg_wdata_i;
          CFG_DIST:   dist_q   <= cfg_wdata_i;
          default:    alpha_q  <= alpha_q;
        endcase
      end
      case (ctrl_i.op)
        OP_PREDICT: begin
          pos_x_q   <= pos_x_q + item_i.inertial_x - prev_ix_q;
          pos_y_q   <= pos_y_q + item_i.inertial_y - prev_iy_q;
          yaw_q     <= item_i.yaw_in;
          prev_ix_q <= item_i.inertial_x;
          prev_iy_q <= item_i.inertial_y;
        end
        OP_LATCH_FIX: begin
          prev_cnt_q <= item_i.gnss_count;
          seen_q     <= 1'b1;
        end
        OP_UPD_X: pos_x_q <= pos_x_q + delta;
        OP_UPD_Y: pos_y_q <= pos_y_q + delta;
        OP_FRAME: begin
          pos_x_q    <= '0;
          pos_y_q    <= '0;
          yaw_q      <= item_i.yaw_in;
          alpha_q    <= ALPHA_RESET;
          ready_q    <= 1'b1;
          seen_q     <= 1'b0;
          prev_cnt_q <= item_i.gnss_count;
          prev_ix_q  <= item_i.inertial_x;
          prev_iy_q  <= item_i.inertial_y;
        end
        default: ;
      endcase
      if (start_i) begin
        status_q <= ST_NOT_READY;
      end else if (ctrl_i.stat_we) begin
        status_q <= ctrl_i.stat;
      end
    end
  end

  // Flags for the sequencer
  assign flags_o.kind    = item_i.kind;
  assign flags_o.ready   = ready_q;
  assign flags_o.fix_new = item_i.gnss_valid & item_i.gnss_origin_set
                         & (item_i.gnss_count != prev_cnt_q);
  assign flags_o.far     = (mag_x > {{(ERR_W-LIM_W){1'b0}}, lim})
                         | (mag_y > {{(ERR_W-LIM_W){1'b0}}, lim});
  assign flags_o.acc_pos = ~acc_q[PROD_W-1] & (|acc_q);

  // Result word
  assign res_o.fused_x     = pos_x_q;
  assign res_o.fused_y     = pos_y_q;
  assign res_o.yaw_out     = yaw_q;
  assign res_o.frame_ready = ready_q;
  assign res_o.gnss_seen   = seen_q;
  assign res_o.status      = status_q;

endmodule

// ----- design/gnss_inertial_complementary_fusion.sv -----
// ---------------------------------------------------------------------------
// gnss_inertial_complementary_fusion
// GNSS / inertial complementary position fusion, micro-programmed.
// ---------------------------------------------------------------------------
// One input word is taken at a time; the next is taken as soon as the
// previous result sits in the output register. A word is first captured and
// then runs 3 micro-steps (frame reset or not-ready tick), 4
// micro-steps (inertial-only tick), 13 or 18 micro-steps (fix rejected by the
// per-axis or by the squared distance check) up to 21 micro-steps (tick with
// an accepted GNSS fix); the last step holds while the output stalls. The
// micro-program runs every product of the rotation, the distance check and
// the blend through one shared 41 x 25 bit multiplier, one per step. Make
// configuration writes only while no word is in flight.
// ---------------------------------------------------------------------------
module gnss_inertial_complementary_fusion import gicf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [39:0] inertial_x, [79:40] inertial_y, [95:80] yaw_in,
  // [135:96] gnss_east, [175:136] gnss_north, [176] gnss_valid,
  // [177] gnss_origin_set, [193:178] gnss_count, [199:194] zero
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // [0] kind
  input  logic [0:0]             s_axis_tuser,
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [39:0] fused_x, [79:40] fused_y, [95:80] yaw_out, [96] frame_ready,
  // [97] gnss_seen, [100:98] status, [103:101] zero
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  logic                  in_acc;
  item_t                 item_q;
  ctrl_t                 ctrl;
  flags_t                flags;
  res_t                  res;
  logic                  busy, done, out_free;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign s_axis_tready = ~busy;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.kind            <= s_axis_tuser[0];
      item_q.inertial_x      <= s_axis_tdata[POS_W-1:0];
      item_q.inertial_y      <= s_axis_tdata[2*POS_W-1:POS_W];
      item_q.yaw_in          <= s_axis_tdata[2*POS_W+YAW_W-1:2*POS_W];
      item_q.gnss_east       <= s_axis_tdata[3*POS_W+YAW_W-1:2*POS_W+YAW_W];
      item_q.gnss_north      <= s_axis_tdata[4*POS_W+YAW_W-1:3*POS_W+YAW_W];
      item_q.gnss_valid      <= s_axis_tdata[4*POS_W+YAW_W];
      item_q.gnss_origin_set <= s_axis_tdata[4*POS_W+YAW_W+1];
      item_q.gnss_count      <= s_axis_tdata[IN_FIELDS_W-1:4*POS_W+YAW_W+2];
    end
  end

  gicf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .out_free_i (out_free),
    .flags_i    (flags),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .done_o     (done)
  );

  gicf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .ctrl_i      (ctrl),
    .item_i      (item_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .flags_o     (flags),
    .res_o       (res)
  );

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, res.status, res.gnss_seen,
                     res.frame_ready, res.yaw_out, res.fused_y, res.fused_x};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
